// ===== src/idcp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the intra DC predictor.
// Used by every module of the block; depends on nothing.
package idcp_pkg;

	localparam int MIN_SIDE_LOG2 = 2;
	localparam int MAX_SIDE_LOG2 = 6;
	localparam int SUM_W = 14;
	localparam int RECIP_W = 7;
	localparam int DC_SHIFT = 9;
	localparam int ADDR_W = 3;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [3:0] BIT_DEPTH_RESET = 4'd8;
	localparam logic [3:0] BIT_DEPTH_MAX = 4'd8;
	localparam logic [0:0] REG_BIT_DEPTH = 1'b0;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	typedef struct packed {
		logic [2:0] width_log2;
		logic [2:0] height_log2;
		logic       above_avail;
		logic       left_avail;
	} blk_info_t;

	function automatic logic [2:0] clamp_log2(input logic [2:0] v);
		logic [2:0] r;
		r = v;
		if (r < 3'(MIN_SIDE_LOG2)) r = 3'(MIN_SIDE_LOG2);
		if (r > 3'(MAX_SIDE_LOG2)) r = 3'(MAX_SIDE_LOG2);
		return r;
	endfunction

	// floor(512 / (w + h)) for every legal block shape
	function automatic logic [RECIP_W-1:0] dc_recip(input logic [7:0] n);
		logic [RECIP_W-1:0] r;
		case (n)
			8'd8:    r = 7'd64;
			8'd12:   r = 7'd42;
			8'd16:   r = 7'd32;
			8'd20:   r = 7'd25;
			8'd24:   r = 7'd21;
			8'd32:   r = 7'd16;
			8'd36:   r = 7'd14;
			8'd40:   r = 7'd12;
			8'd48:   r = 7'd10;
			8'd64:   r = 7'd8;
			8'd68:   r = 7'd7;
			8'd72:   r = 7'd7;
			8'd80:   r = 7'd6;
			8'd96:   r = 7'd5;
			8'd128:  r = 7'd4;
			default: r = 7'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/intra_dc_predictor.sv =====
`timescale 1ns / 1ps
// Intra DC predictor top level: APB register, input stage, result stage.
// A finish beat passes the input register, then the result register, before
// its DC value shows on the output.
// Throughput: one beat per cycle; a finish stalls only while the result
// register still holds an untaken value. Reset clears both accumulators,
// all valid flags, and sets bit_depth to 8.
module intra_dc_predictor import idcp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [7:0]        ref_sample,
	input  logic              from_left,
	input  logic [2:0]        width_log2,
	input  logic [2:0]        height_log2,
	input  logic              above_avail,
	input  logic              left_avail,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        dc_value
);

	logic [3:0]       bit_depth_q;
	logic             valid_s1, kind_s1, from_left_s1;
	logic [7:0]       sample_s1;
	blk_info_t        info_s1;
	logic             valid_s2;
	logic [7:0]       dc_s2;
	logic             advance, fin_adv, in_acc;
	logic [SUM_W-1:0] left_sum, above_sum;
	logic [7:0]       dc_calc;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BIT_DEPTH) ? {28'd0, bit_depth_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_depth_q <= BIT_DEPTH_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_BIT_DEPTH) begin
			bit_depth_q <= pwdata[3:0];
		end
	end

	// a sample always drains; a finish needs room in the result register
	assign advance  = valid_s1 && (kind_s1 == KIND_SAMPLE || !valid_s2 || out_ready);
	assign fin_adv  = advance && kind_s1 == KIND_FINISH;
	assign in_ready = !valid_s1 || advance;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1      <= kind;
			sample_s1    <= ref_sample;
			from_left_s1 <= from_left;
			info_s1      <= '{width_log2, height_log2, above_avail, left_avail};
		end
	end

	idcp_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (advance && kind_s1 == KIND_SAMPLE),
		.clr       (fin_adv),
		.from_left (from_left_s1),
		.sample    (sample_s1),
		.left_sum  (left_sum),
		.above_sum (above_sum)
	);

	idcp_calc u_calc (
		.info      (info_s1),
		.left_sum  (left_sum),
		.above_sum (above_sum),
		.bit_depth (bit_depth_q),
		.dc_value  (dc_calc)
	);

	// result register: hold until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fin_adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_adv) begin
			dc_s2 <= dc_calc;
		end
	end

	assign out_valid = valid_s2;
	assign dc_value  = dc_s2;

	a_clear_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		fin_adv |=> (left_sum == '0 && above_sum == '0))
		else $error("accumulators not cleared after finish");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(fin_adv))
		else $error("result raised without a finish");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(kind_s1) && $stable(sample_s1))
		else $error("input stage overwritten while stalled");

endmodule

// ===== src/idcp_acc.sv =====
`timescale 1ns / 1ps
// Left and above neighbour accumulators with saturation and clear on finish.
// Depends on idcp_pkg.
module idcp_acc import idcp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             upd,
	input  logic             clr,
	input  logic             from_left,
	input  logic [7:0]       sample,
	output logic [SUM_W-1:0] left_sum,
	output logic [SUM_W-1:0] above_sum
);

	logic [SUM_W-1:0] left_q, above_q;
	logic [SUM_W:0]   sel_sum;
	logic [SUM_W-1:0] sat_sum;

	assign sel_sum = (from_left ? {1'b0, left_q} : {1'b0, above_q}) + (SUM_W+1)'(sample);
	assign sat_sum = (sel_sum > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sel_sum[SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			above_q <= '0;
		end else if (clr) begin
			left_q  <= '0;
			above_q <= '0;
		end else if (upd) begin
			if (from_left) begin
				left_q <= sat_sum;
			end else begin
				above_q <= sat_sum;
			end
		end
	end

	assign left_sum  = left_q;
	assign above_sum = above_q;

endmodule

// ===== src/idcp_calc.sv =====
`timescale 1ns / 1ps
// DC value from the two sums, block shape, availability and bit depth.
// Depends on idcp_pkg (clamp and reciprocal table).
module idcp_calc import idcp_pkg::*; (
	input  blk_info_t        info,
	input  logic [SUM_W-1:0] left_sum,
	input  logic [SUM_W-1:0] above_sum,
	input  logic [3:0]       bit_depth,
	output logic [7:0]       dc_value
);

	localparam int TOT_W = SUM_W + 2;
	localparam int PROD_W = TOT_W + RECIP_W;

	logic [2:0]        wl, hl;
	logic [7:0]        w, h, n;
	logic [TOT_W-1:0]  total;
	logic [PROD_W-1:0] prod;
	logic [SUM_W:0]    left_rnd, above_rnd;
	logic [3:0]        bd;
	logic [SUM_W-1:0]  v;

	assign wl = clamp_log2(info.width_log2);
	assign hl = clamp_log2(info.height_log2);
	assign w  = 8'd1 << wl;
	assign h  = 8'd1 << hl;
	assign n  = w + h;

	assign total = TOT_W'(left_sum) + TOT_W'(above_sum) + TOT_W'(n >> 1);
	assign prod  = PROD_W'(total) * PROD_W'(dc_recip(n));

	assign left_rnd  = (SUM_W+1)'(left_sum) + (SUM_W+1)'(h >> 1);
	assign above_rnd = (SUM_W+1)'(above_sum) + (SUM_W+1)'(w >> 1);

	always_comb begin
		bd = bit_depth;
		if (bd == 4'd0) bd = 4'd1;
		if (bd > BIT_DEPTH_MAX) bd = BIT_DEPTH_MAX;
		if (info.left_avail && info.above_avail) begin
			v = prod[DC_SHIFT +: SUM_W];
		end else if (info.left_avail) begin
			v = SUM_W'(left_rnd >> hl);
		end else if (info.above_avail) begin
			v = SUM_W'(above_rnd >> wl);
		end else begin
			v = SUM_W'(1) << (bd - 4'd1);
		end
		dc_value = (v > SUM_W'(255)) ? 8'd255 : v[7:0];
	end

endmodule
